// ----- rtl/audio_window_loudness_meter_assert.svh -----
`ifndef AUDIO_WINDOW_LOUDNESS_METER_ASSERT_SVH
`define AUDIO_WINDOW_LOUDNESS_METER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define AWLM_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AWLM_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/awlm_pkg.sv -----
package awlm_pkg;

   localparam int unsigned MAX_WINDOW_SAMPLES_DEF = 16384;

   localparam int unsigned SAMPLE_W    = 32;
   localparam int unsigned LEVEL_W     = 16;
   localparam int unsigned SUM_W       = 64;
   localparam int unsigned DIGIT_W     = 16;
   localparam int unsigned SCALE_W     = 9;
   localparam int unsigned GAIN_W      = 2;
   localparam int unsigned SHIFT_W     = 5;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 5;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(12);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_METER_MODE   = 2'd0,
      CSR_GAIN_LEVEL   = 2'd1,
      CSR_SHIFT_AMOUNT = 2'd2,
      CSR_DROP_ZERO    = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_PEAK = 1'b0,
      MODE_RMS  = 1'b1
   } mode_type;

   typedef enum logic [GAIN_W-1:0] {
      GAIN_LOW    = 2'd0,
      GAIN_MEDIUM = 2'd1,
      GAIN_HIGH   = 2'd2
   } gain_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_CLOSE,
      ST_MEAN,
      ST_ROOT,
      ST_SCALE,
      ST_DONE
   } state_type;

   function automatic logic [SCALE_W-1:0] scale_of(input logic [GAIN_W-1:0] gain);
      logic [SCALE_W-1:0] scale;
      case (gain)
         GAIN_LOW:    scale = SCALE_W'(300);
         GAIN_MEDIUM: scale = SCALE_W'(60);
         default:     scale = SCALE_W'(15);
      endcase
      return scale;
   endfunction

endpackage

// ----- rtl/awlm_req_if.sv -----
interface awlm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic signed [awlm_pkg::SAMPLE_W-1:0] raw_sample;

   modport source (output valid, output req_type, output raw_sample, input ready);
   modport sink   (input valid, input req_type, input raw_sample, output ready);
endinterface

// ----- rtl/awlm_rsp_if.sv -----
interface awlm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [awlm_pkg::LEVEL_W-1:0] loudness;
   logic                         saturated;
   logic                         empty_window;

   modport source (output valid, output loudness, output saturated, output empty_window,
                   input ready);
   modport sink   (input valid, input loudness, input saturated, input empty_window,
                   output ready);
endinterface

// ----- rtl/audio_window_loudness_meter.sv -----
// Sample item: squared as two 16-bit digits; the next item is taken on the last digit step,
// while that digit is added. Window-end item: an empty window or an overflowed RMS sum goes
// straight to the result; peak mode runs the span through a 64-step scale divide, RMS mode a
// 64-step mean divide, 32-step square root and 64-step scale divide (one restoring unit).
// Synchronous active-high reset: registers to defaults, accumulators cleared, no item held.
`include "audio_window_loudness_meter_assert.svh"

module audio_window_loudness_meter #(
   parameter int unsigned MAX_WINDOW_SAMPLES = awlm_pkg::MAX_WINDOW_SAMPLES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   awlm_req_if.sink                           req_chan,
   awlm_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [awlm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [awlm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned SAMPLE_W  = awlm_pkg::SAMPLE_W;
   localparam int unsigned SUM_W     = awlm_pkg::SUM_W;
   localparam int unsigned DIGIT_W   = awlm_pkg::DIGIT_W;
   localparam int unsigned LEVEL_W   = awlm_pkg::LEVEL_W;
   localparam int unsigned SCALE_W   = awlm_pkg::SCALE_W;
   localparam int unsigned TALLY_W   = $clog2(MAX_WINDOW_SAMPLES + 1);
   localparam int unsigned DEN_W     = (TALLY_W > SCALE_W) ? TALLY_W : SCALE_W;
   localparam int unsigned N_DIGITS  = SAMPLE_W / DIGIT_W;
   localparam int unsigned DIG_W     = (N_DIGITS > 1) ? $clog2(N_DIGITS) : 1;
   localparam int unsigned PROD_W    = SAMPLE_W + DIGIT_W;
   localparam int unsigned ROOT_W    = SUM_W / 2;
   localparam int unsigned RREM_W    = ROOT_W + 2;
   localparam int unsigned STEP_W    = $clog2(SUM_W);

   awlm_pkg::state_type state_ff, state_in;

   logic                            mode_ff, mode_in;
   logic [awlm_pkg::GAIN_W-1:0]     gain_ff, gain_in;
   logic [awlm_pkg::SHIFT_W-1:0]    shift_ff, shift_in;
   logic                            drop_ff, drop_in;

   logic signed [SAMPLE_W-1:0]      min_ff, min_in;
   logic signed [SAMPLE_W-1:0]      max_ff, max_in;
   logic [SUM_W-1:0]                sum_ff, sum_in;
   logic                            ovf_ff, ovf_in;
   logic [TALLY_W-1:0]              tally_ff, tally_in;

   logic [SAMPLE_W-1:0]             mag_ff, mag_in;
   logic [SAMPLE_W-1:0]             dsr_ff, dsr_in;
   logic [DIG_W-1:0]                dig_ff, dig_in;

   logic [STEP_W-1:0]               step_ff, step_in;
   logic [SUM_W-1:0]                quo_ff, quo_in;
   logic [DEN_W-1:0]                rem_ff, rem_in;
   logic [DEN_W-1:0]                den_ff, den_in;
   logic [SUM_W-1:0]                rad_ff, rad_in;
   logic [ROOT_W-1:0]               root_ff, root_in;
   logic [RREM_W-1:0]               rrem_ff, rrem_in;
   logic                            empty_ff, empty_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]              loud_ff, loud_in;
   logic                            sat_ff, sat_in;
   logic                            rsp_empty_ff, rsp_empty_in;

   logic                            req_ready;
   logic                            req_fire;
   logic signed [SAMPLE_W-1:0]      sample_s;
   logic [SAMPLE_W-1:0]             sample_mag;
   logic                            dropped;
   logic                            full;
   logic                            last_digit;
   logic [PROD_W-1:0]               pp;
   logic [SUM_W-1:0]                addend;
   logic [SUM_W:0]                  sum_add;
   logic [DEN_W:0]                  trial;
   logic                            ge;
   logic [DEN_W-1:0]                rem_next;
   logic [SUM_W-1:0]                quo_next;
   logic [RREM_W+1:0]               rt;
   logic [RREM_W+1:0]               rtrial;
   logic                            rge;
   logic [RREM_W-1:0]               rrem_next;
   logic [ROOT_W-1:0]               root_next;
   logic [SAMPLE_W-1:0]             span;
   logic [SCALE_W-1:0]              scale;
   logic                            step_last;
   logic                            root_last;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.loudness     = loud_ff;
   assign rsp_chan.saturated    = sat_ff;
   assign rsp_chan.empty_window = rsp_empty_ff;
   assign req_chan.ready        = req_ready;

   always_comb begin
      last_digit = (dig_ff == DIG_W'(N_DIGITS - 1));
      req_ready  = (state_ff == awlm_pkg::ST_IDLE) ||
                   ((state_ff == awlm_pkg::ST_SQUARE) && last_digit);
      req_fire   = req_chan.valid && req_ready;

      sample_s   = req_chan.raw_sample >>> shift_ff;
      sample_mag = sample_s[SAMPLE_W-1] ? SAMPLE_W'(-sample_s) : SAMPLE_W'(sample_s);
      dropped    = drop_ff && ((req_chan.raw_sample == '0) || (req_chan.raw_sample == '1));
      full       = (tally_ff >= TALLY_W'(MAX_WINDOW_SAMPLES));

      // one digit of the square per cycle
      pp      = PROD_W'(mag_ff) * PROD_W'(dsr_ff[DIGIT_W-1:0]);
      addend  = SUM_W'(pp) << (DIGIT_W * dig_ff);
      sum_add = {1'b0, sum_ff} + {1'b0, addend};

      // restoring divider, one quotient bit per cycle
      trial    = {rem_ff, quo_ff[SUM_W-1]};
      ge       = (trial >= {1'b0, den_ff});
      rem_next = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
      quo_next = {quo_ff[SUM_W-2:0], ge};

      // square root, one result bit per cycle
      rt        = {rrem_ff, rad_ff[SUM_W-1 -: 2]};
      rtrial    = {2'b00, root_ff, 2'b01};
      rge       = (rt >= rtrial);
      rrem_next = rge ? RREM_W'(rt - rtrial) : rt[RREM_W-1:0];
      root_next = {root_ff[ROOT_W-2:0], rge};

      span      = SAMPLE_W'(max_ff - min_ff);
      scale     = awlm_pkg::scale_of(gain_ff);
      step_last = (step_ff == STEP_W'(SUM_W - 1));
      root_last = (step_ff == STEP_W'(ROOT_W - 1));

      state_in     = state_ff;
      mode_in      = mode_ff;
      gain_in      = gain_ff;
      shift_in     = shift_ff;
      drop_in      = drop_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      tally_in     = tally_ff;
      mag_in       = mag_ff;
      dsr_in       = dsr_ff;
      dig_in       = dig_ff;
      step_in      = step_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      rrem_in      = rrem_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff;
      loud_in      = loud_ff;
      sat_in       = sat_ff;
      rsp_empty_in = rsp_empty_ff;

      if (csr_we) begin
         case (csr_index)
            awlm_pkg::CSR_METER_MODE:   mode_in  = csr_wdata[0];
            awlm_pkg::CSR_GAIN_LEVEL:   gain_in  = csr_wdata[awlm_pkg::GAIN_W-1:0];
            awlm_pkg::CSR_SHIFT_AMOUNT: shift_in = csr_wdata[awlm_pkg::SHIFT_W-1:0];
            awlm_pkg::CSR_DROP_ZERO:    drop_in  = csr_wdata[0];
            default: ;
         endcase
      end

      if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         awlm_pkg::ST_IDLE: ;
         awlm_pkg::ST_SQUARE: begin
            if (ovf_ff || sum_add[SUM_W]) begin
               sum_in = '1;
               ovf_in = 1'b1;
            end else begin
               sum_in = sum_add[SUM_W-1:0];
            end
            dsr_in = dsr_ff >> DIGIT_W;
            dig_in = DIG_W'(dig_ff + 1'b1);
            if (last_digit) begin
               state_in = awlm_pkg::ST_IDLE;
            end
         end
         awlm_pkg::ST_CLOSE: begin
            step_in  = '0;
            rem_in   = '0;
            empty_in = (tally_ff == '0);
            den_in   = DEN_W'(scale);
            if (tally_ff == '0) begin
               quo_in   = '0;
               state_in = awlm_pkg::ST_DONE;
            end else if (mode_ff == awlm_pkg::MODE_PEAK) begin
               quo_in   = SUM_W'(span);
               state_in = awlm_pkg::ST_SCALE;
            end else if (ovf_ff) begin
               quo_in   = SUM_W'(1) << LEVEL_W;
               state_in = awlm_pkg::ST_DONE;
            end else begin
               quo_in   = sum_ff;
               den_in   = DEN_W'(tally_ff);
               state_in = awlm_pkg::ST_MEAN;
            end
            min_in   = {1'b0, {(SAMPLE_W-1){1'b1}}};
            max_in   = {1'b1, {(SAMPLE_W-1){1'b0}}};
            sum_in   = '0;
            ovf_in   = 1'b0;
            tally_in = '0;
         end
         awlm_pkg::ST_MEAN: begin
            quo_in  = quo_next;
            rem_in  = rem_next;
            step_in = STEP_W'(step_ff + 1'b1);
            if (step_last) begin
               rad_in   = quo_next;
               root_in  = '0;
               rrem_in  = '0;
               step_in  = '0;
               state_in = awlm_pkg::ST_ROOT;
            end
         end
         awlm_pkg::ST_ROOT: begin
            rad_in  = rad_ff << 2;
            root_in = root_next;
            rrem_in = rrem_next;
            step_in = STEP_W'(step_ff + 1'b1);
            if (root_last) begin
               quo_in   = SUM_W'(root_next);
               rem_in   = '0;
               den_in   = DEN_W'(scale);
               step_in  = '0;
               state_in = awlm_pkg::ST_SCALE;
            end
         end
         awlm_pkg::ST_SCALE: begin
            quo_in  = quo_next;
            rem_in  = rem_next;
            step_in = STEP_W'(step_ff + 1'b1);
            if (step_last) begin
               state_in = awlm_pkg::ST_DONE;
            end
         end
         awlm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               sat_in       = |quo_ff[SUM_W-1:LEVEL_W];
               loud_in      = (|quo_ff[SUM_W-1:LEVEL_W]) ? '1 : quo_ff[LEVEL_W-1:0];
               rsp_empty_in = empty_ff;
               state_in     = awlm_pkg::ST_IDLE;
            end
         end
         default: state_in = awlm_pkg::ST_IDLE;
      endcase

      // item taken in idle or on the last square digit
      if (req_fire) begin
         if (req_chan.req_type) begin
            state_in = awlm_pkg::ST_CLOSE;
         end else if (!dropped && !full) begin
            if (sample_s < min_ff) begin
               min_in = sample_s;
            end
            if (sample_s > max_ff) begin
               max_in = sample_s;
            end
            tally_in = TALLY_W'(tally_ff + 1'b1);
            mag_in   = sample_mag;
            dsr_in   = sample_mag;
            dig_in   = '0;
            state_in = awlm_pkg::ST_SQUARE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= awlm_pkg::ST_IDLE;
         mode_ff      <= awlm_pkg::MODE_PEAK;
         gain_ff      <= awlm_pkg::GAIN_HIGH;
         shift_ff     <= awlm_pkg::SHIFT_RESET;
         drop_ff      <= 1'b0;
         min_ff       <= {1'b0, {(SAMPLE_W-1){1'b1}}};
         max_ff       <= {1'b1, {(SAMPLE_W-1){1'b0}}};
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         gain_ff      <= gain_in;
         shift_ff     <= shift_in;
         drop_ff      <= drop_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      dsr_ff       <= dsr_in;
      dig_ff       <= dig_in;
      step_ff      <= step_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      rad_ff       <= rad_in;
      root_ff      <= root_in;
      rrem_ff      <= rrem_in;
      empty_ff     <= empty_in;
      loud_ff      <= loud_in;
      sat_ff       <= sat_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   `AWLM_NEXT(a_close_starts, req_fire && req_chan.req_type, state_ff == awlm_pkg::ST_CLOSE, "window-end item did not start the close")
   `AWLM_IMPLIES(a_sat_clamps, rsp_chan.valid && rsp_chan.saturated, rsp_chan.loudness == '1, "saturated level not clamped")
   `AWLM_IMPLIES(a_empty_quiet, rsp_chan.valid && rsp_chan.empty_window, (rsp_chan.loudness == '0) && !rsp_chan.saturated, "empty window gave a level")
   `AWLM_IMPLIES(a_tally_bound, 1'b1, tally_ff <= TALLY_W'(MAX_WINDOW_SAMPLES), "sample count beyond window size")

endmodule

// ----- tb/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   LEVEL_W    = awlm_pkg::LEVEL_W;
   localparam int   GAIN_W     = awlm_pkg::GAIN_W;
   localparam int   SHIFT_W    = awlm_pkg::SHIFT_W;
   localparam int   CSR_DATA_W = awlm_pkg::CSR_DATA_W;

   localparam logic ITEM_SAMPLE = 1'b0;
   localparam logic ITEM_CLOSE  = 1'b1;
   localparam int   SETTLE_CYCLES = 200;
   localparam int   CYCLE_LIMIT   = 1_000_000;
   localparam int   WINDOW_CAP    = awlm_pkg::MAX_WINDOW_SAMPLES_DEF;

   typedef struct packed {
      logic [LEVEL_W-1:0] loudness;
      logic               saturated;
      logic               empty_window;
   } window_level_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   awlm_pkg::csr_index_type csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   awlm_req_if req_bus ();
   awlm_rsp_if rsp_bus ();

   audio_window_loudness_meter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // meter settings as last written
   awlm_pkg::mode_type  cfg_mode;
   logic [GAIN_W-1:0]   cfg_gain;
   logic [SHIFT_W-1:0]  cfg_shift;
   logic                cfg_drop;

   // window accumulators
   logic signed [31:0]  win_lo;
   logic signed [31:0]  win_hi;
   longint unsigned     energy;
   int                  tally;
   logic                energy_stuck;

   window_level_type    pending_levels[$];

   int send_idle_pct;
   int recv_stall_pct;
   int items_sent;
   int windows_checked;
   int reg_writes;
   int mismatches;
   int cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic longint unsigned root_floor(input longint unsigned x);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   function automatic longint unsigned divisor_for(input logic [GAIN_W-1:0] g);
      case (g)
         awlm_pkg::GAIN_LOW:    return 300;
         awlm_pkg::GAIN_MEDIUM: return 60;
         default:               return 15;
      endcase
   endfunction

   function automatic void clear_window();
      win_lo       = 32'sh7FFF_FFFF;
      win_hi       = 32'sh8000_0000;
      energy       = 0;
      tally        = 0;
      energy_stuck = 1'b0;
   endfunction

   function automatic void predict_item(input logic kind, input logic [31:0] word);
      logic signed [31:0] s;
      longint             wide;
      longint unsigned    sq;
      longint unsigned    level;
      window_level_type   res;
      if (kind == ITEM_SAMPLE) begin
         if (cfg_drop && (word == 32'h0 || word == 32'hFFFF_FFFF)) return;
         if (tally >= WINDOW_CAP) return;
         s = $signed(word) >>> cfg_shift;
         if (s < win_lo) win_lo = s;
         if (s > win_hi) win_hi = s;
         wide = s;
         if (wide < 0) wide = -wide;
         sq = longint'(wide) * longint'(wide);
         if (energy_stuck || energy > (~64'd0 - sq)) begin
            energy       = ~64'd0;
            energy_stuck = 1'b1;
         end else begin
            energy = energy + sq;
         end
         tally++;
      end else begin
         level = 0;
         res   = '0;
         if (tally == 0)
            res.empty_window = 1'b1;
         else if (cfg_mode == awlm_pkg::MODE_PEAK)
            level = longint'(longint'(win_hi) - longint'(win_lo)) / divisor_for(cfg_gain);
         else if (energy_stuck)
            level = 65536;
         else
            level = root_floor(energy / longint'(tally)) / divisor_for(cfg_gain);
         if (level > 65535) begin
            level = 65535;
            res.saturated = 1'b1;
         end
         res.loudness = level[LEVEL_W-1:0];
         pending_levels.push_back(res);
         clear_window();
      end
   endfunction

   always @(posedge clock) begin
      window_level_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_levels.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected level, expected none, actual %0d sat %0b empty %0b",
                     $time, rsp_bus.loudness, rsp_bus.saturated, rsp_bus.empty_window);
         end else begin
            want = pending_levels.pop_front();
            windows_checked++;
            if (rsp_bus.loudness !== want.loudness) begin
               mismatches++;
               $display("%0t: loudness expected %0d actual %0d",
                        $time, want.loudness, rsp_bus.loudness);
            end
            if (rsp_bus.saturated !== want.saturated) begin
               mismatches++;
               $display("%0t: saturated expected %0b actual %0b",
                        $time, want.saturated, rsp_bus.saturated);
            end
            if (rsp_bus.empty_window !== want.empty_window) begin
               mismatches++;
               $display("%0t: empty_window expected %0b actual %0b",
                        $time, want.empty_window, rsp_bus.empty_window);
            end
         end
      end
   end

   task automatic send_item(input logic kind, input logic [31:0] word);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid      <= 1'b0;
         req_bus.raw_sample <= $urandom;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.raw_sample <= word;
      do @(posedge clock); while (!req_bus.ready);
      predict_item(kind, word);
      items_sent++;
   endtask

   // hold off until every level is back and the block has gone quiet
   task automatic drain_meter();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input awlm_pkg::csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         awlm_pkg::CSR_METER_MODE:   cfg_mode  = awlm_pkg::mode_type'(val[0]);
         awlm_pkg::CSR_GAIN_LEVEL:   cfg_gain  = val[GAIN_W-1:0];
         awlm_pkg::CSR_SHIFT_AMOUNT: cfg_shift = val[SHIFT_W-1:0];
         default:                    cfg_drop  = val[0];
      endcase
      reg_writes++;
   endtask

   task automatic configure(input awlm_pkg::mode_type m, input logic [GAIN_W-1:0] g,
                            input logic [SHIFT_W-1:0] sh, input logic drop);
      drain_meter();
      write_reg(awlm_pkg::CSR_METER_MODE, CSR_DATA_W'(m));
      write_reg(awlm_pkg::CSR_GAIN_LEVEL, CSR_DATA_W'(g));
      write_reg(awlm_pkg::CSR_SHIFT_AMOUNT, CSR_DATA_W'(sh));
      write_reg(awlm_pkg::CSR_DROP_ZERO, CSR_DATA_W'(drop));
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return ($urandom_range(1) != 0) ? 32'h0 : 32'hFFFF_FFFF;
         3, 4:    return 32'($urandom_range(200000)) - 32'd100000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SHIFT_W-1:0] pick_shift();
      case ($urandom_range(4))
         0:       return SHIFT_W'(0);
         1:       return SHIFT_W'(31);
         2:       return SHIFT_W'(12);
         3:       return SHIFT_W'(14);
         default: return SHIFT_W'($urandom_range(31));
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_item(ITEM_CLOSE, 32'h0);
      send_item(ITEM_SAMPLE, 32'sd1000 <<< 12);
      send_item(ITEM_SAMPLE, -(32'sd1000 <<< 12));
      send_item(ITEM_CLOSE, 32'hFFFF_FFFF);
   endtask

   task automatic test_peak_extremes();
      configure(awlm_pkg::MODE_PEAK, awlm_pkg::GAIN_HIGH, SHIFT_W'(0), 1'b0);
      send_item(ITEM_SAMPLE, 32'h7FFF_FFFF);
      send_item(ITEM_SAMPLE, 32'h8000_0000);
      send_item(ITEM_CLOSE, 32'h0);
      configure(awlm_pkg::MODE_PEAK, awlm_pkg::GAIN_LOW, SHIFT_W'(31), 1'b0);
      send_item(ITEM_SAMPLE, 32'h8000_0000);
      send_item(ITEM_SAMPLE, 32'h7FFF_FFFF);
      send_item(ITEM_CLOSE, 32'h0);
   endtask

   task automatic test_rms_gains();
      configure(awlm_pkg::MODE_RMS, awlm_pkg::GAIN_MEDIUM, SHIFT_W'(14), 1'b0);
      send_item(ITEM_SAMPLE, 32'h1234_5678);
      send_item(ITEM_SAMPLE, 32'hC000_0000);
      send_item(ITEM_CLOSE, 32'h0);
      // gain code 3 falls back to the high gain divisor
      configure(awlm_pkg::MODE_RMS, 2'd3, SHIFT_W'(0), 1'b0);
      send_item(ITEM_SAMPLE, 32'h8000_0000);
      send_item(ITEM_CLOSE, 32'h0);
   endtask

   task automatic test_square_overflow();
      configure(awlm_pkg::MODE_RMS, awlm_pkg::GAIN_LOW, SHIFT_W'(0), 1'b0);
      repeat (5) send_item(ITEM_SAMPLE, 32'h8000_0000);
      send_item(ITEM_CLOSE, 32'h0);
      // same window in peak mode: min/max still tracked
      configure(awlm_pkg::MODE_PEAK, awlm_pkg::GAIN_LOW, SHIFT_W'(0), 1'b0);
      repeat (5) send_item(ITEM_SAMPLE, 32'h8000_0000);
      send_item(ITEM_CLOSE, 32'h0);
   endtask

   task automatic test_drop_words();
      configure(awlm_pkg::MODE_PEAK, awlm_pkg::GAIN_HIGH, SHIFT_W'(12), 1'b1);
      send_item(ITEM_SAMPLE, 32'h0);
      send_item(ITEM_SAMPLE, 32'hFFFF_FFFF);
      send_item(ITEM_CLOSE, 32'h0);
      configure(awlm_pkg::MODE_PEAK, awlm_pkg::GAIN_HIGH, SHIFT_W'(0), 1'b0);
      send_item(ITEM_SAMPLE, 32'h0);
      send_item(ITEM_SAMPLE, 32'hFFFF_FFFF);
      send_item(ITEM_CLOSE, 32'h0);
   endtask

   task automatic test_random_windows(input int budget);
      int sent;
      int len;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(3) == 0)
            configure(awlm_pkg::mode_type'($urandom_range(1)), GAIN_W'($urandom_range(3)),
                      pick_shift(), 1'($urandom_range(1)));
         len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(12);
         repeat (len) send_item(ITEM_SAMPLE, pick_word());
         send_item(ITEM_CLOSE, $urandom);
         sent += len + 1;
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = awlm_pkg::CSR_METER_MODE;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = ITEM_SAMPLE;
      req_bus.raw_sample = '0;
      rsp_bus.ready      = 1'b0;
      cycles             = 0;
      items_sent         = 0;
      windows_checked    = 0;
      reg_writes         = 0;
      mismatches         = 0;
      cfg_mode           = awlm_pkg::MODE_PEAK;
      cfg_gain           = awlm_pkg::GAIN_HIGH;
      cfg_shift          = awlm_pkg::SHIFT_RESET;
      cfg_drop           = 1'b0;
      clear_window();

      send_idle_pct  = 26;
      recv_stall_pct = 87;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_peak_extremes();
      test_rms_gains();
      test_square_overflow();
      test_drop_words();
      test_random_windows(330);

      drain_meter();
      send_idle_pct  = 87;
      recv_stall_pct = 26;
      test_random_windows(330);

      drain_meter();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_windows(340);

      drain_meter();
      $display("Covered peak and RMS windows over all gain codes, shifts, dropped words,");
      $display("empty windows and square sum overflow: %0d items, %0d levels, %0d writes",
               items_sent, windows_checked, reg_writes);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
